// ----- rtl/b2da_pkg.sv -----
`default_nettype none

package b2da_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int MIN_DIGITS = 2;

    localparam logic [5:0] CHAR_SPACE = 6'd32;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_NINE  = 6'd57;

    typedef struct packed {
        logic [15:0] value;
        logic [2:0]  digit_count;
    } req_t;

    typedef struct packed {
        logic [5:0] character;
        logic       last;
        logic       overflow;
    } res_t;

    typedef struct packed {
        logic        ge;
        logic [16:0] diff;
    } sub_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIGIT
    } state_t;

    function automatic logic [16:0] pow10(input logic [2:0] place);
        logic [16:0] p;
        case (place)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b2da_sub_unit.sv -----
`default_nettype none

module b2da_sub_unit
    import b2da_pkg::*;
(
    input  wire logic [16:0] minuend,
    input  wire logic [16:0] subtrahend,
    output sub_res_t         res
);

    logic [17:0] diff_ext;

    assign diff_ext = {1'b0, minuend} - {1'b0, subtrahend};
    assign res.ge   = ~diff_ext[17];
    assign res.diff = diff_ext[16:0];

endmodule

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii_blanked_core.sv -----
// Channel   Handshake                Payload
// request   start / busy             request.value, request.digit_count
// result    result_strobe (1 cycle)  result.character, result.last, result.overflow
//
// One compare/subtract unit serves the range check and every digit.
// An item runs a range check, then for each digit place it subtracts the power of
// ten until it no longer fits and emits that digit; a saturated item emits nines.
// busy is high from the cycle after start until the last result is registered.
// Reset clears the sequencer and the strobe; the receiver cannot stall results.
`default_nettype none

module binary_to_decimal_ascii_blanked_core
    import b2da_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t request,
    output logic      busy,
    output res_t      result,
    output logic      result_strobe
);

    state_t      state_reg, state_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  digit_reg, digit_next;
    logic [2:0]  place_reg, place_next;
    logic        seen_reg, seen_next;
    logic        ovf_reg, ovf_next;
    res_t        res_reg, res_next;
    logic        strobe_reg, strobe_next;

    logic [16:0] sub_b;
    sub_res_t    sub_res;
    logic [2:0]  width_clamped;
    logic        at_last;

    always_comb
    begin
        if (request.digit_count < 3'(MIN_DIGITS))
            width_clamped = 3'(MIN_DIGITS);
        else if (request.digit_count > 3'(MAX_DIGITS))
            width_clamped = 3'(MAX_DIGITS);
        else
            width_clamped = request.digit_count;
    end

    assign sub_b   = pow10(place_reg);
    assign at_last = (place_reg == 3'd0);

    b2da_sub_unit u_sub (
        .minuend    ({1'b0, rem_reg}),
        .subtrahend (sub_b),
        .res        (sub_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RANGE;
            end
            ST_RANGE:
                state_next = ST_DIGIT;
            ST_DIGIT:
            begin
                if ((ovf_reg || !sub_res.ge) && at_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rem_next    = rem_reg;
        digit_next  = digit_reg;
        place_next  = place_reg;
        seen_next   = seen_reg;
        ovf_next    = ovf_reg;
        res_next    = res_reg;
        strobe_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = request.value;
                    place_next = width_clamped;
                    digit_next = 4'd0;
                    seen_next  = 1'b0;
                end
            end
            ST_RANGE:
            begin
                ovf_next   = sub_res.ge;
                place_next = place_reg - 3'd1;
            end
            ST_DIGIT:
            begin
                if (ovf_reg)
                begin
                    res_next.character = CHAR_NINE;
                    res_next.last      = at_last;
                    res_next.overflow  = 1'b1;
                    strobe_next        = 1'b1;
                    place_next         = place_reg - 3'd1;
                end
                else if (sub_res.ge)
                begin
                    rem_next   = sub_res.diff[15:0];
                    digit_next = digit_reg + 4'd1;
                end
                else
                begin
                    if (digit_reg == 4'd0 && !at_last && !seen_reg)
                        res_next.character = CHAR_SPACE;
                    else
                        res_next.character = CHAR_ZERO + {2'b00, digit_reg};
                    res_next.last     = at_last;
                    res_next.overflow = 1'b0;
                    strobe_next       = 1'b1;
                    seen_next         = seen_reg | (digit_reg != 4'd0);
                    digit_next        = 4'd0;
                    place_next        = place_reg - 3'd1;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        digit_reg <= digit_next;
        place_reg <= place_next;
        seen_reg  <= seen_next;
        ovf_reg   <= ovf_next;
        res_reg   <= res_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result        = res_reg;
    assign result_strobe = strobe_reg;

endmodule

`default_nettype wire

// ----- rtl/b2da_checker.sv -----
`default_nettype none

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire res_t result,
    input wire logic result_strobe
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.character == CHAR_SPACE) ||
            (result.character >= CHAR_ZERO && result.character <= CHAR_NINE))
        else $error("character outside space and digits");

    a_ovf_nine: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.overflow |-> result.character == CHAR_NINE)
        else $error("saturated character is not nine");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !result_strobe)
        else $error("result right after last character");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last |-> busy)
        else $error("non-final character while idle");

endmodule

bind binary_to_decimal_ascii_blanked_core b2da_checker u_b2da_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result        (result),
    .result_strobe (result_strobe)
);

`default_nettype wire
